[sv/frsm_pkg.sv]
// shared constants, segment table and widths for the frame rate seven segment meter
`default_nettype none

package frsm_pkg;

    // counter width default and configuration register layout
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int TICK_RATE_W       = 27;
    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = TICK_RATE_W'(1000000);
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 3;
    localparam int REG_IDX_W         = 1;
    localparam logic [REG_IDX_W-1:0] REG_TICK_RATE = 1'b0;

    // rate is computed in hundredths of a frame per second
    localparam int RATE_SCALE        = 100;
    localparam int DIVIDEND_W        = 34;

    // queue between front and back
    localparam int QUEUE_DEPTH       = 2;

    // display
    localparam int BCD_W             = 16;
    localparam logic [BCD_W-1:0] FORCED_BCD = 16'h9999;
    localparam logic [7:0] POINT_CLEAR = 8'h7F;
    localparam logic [7:0] SEG_BLANK   = 8'hFF;

    // active-low seven-segment code of one decimal digit, point off
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[sv/frame_rate_seven_segment_meter.sv]
// top level: configuration register, front, queue and back of the frame rate meter
//
//  channel   direction  handshake                 payload
//  ------------------------------------------------------------------------------
//  input     in         push / full               i_start_count, i_end_count
//  result    out        empty / pop               o_tens_segments, o_low_segments,
//                                                 o_zero_time
//  config    in/out     psel, penable, pwrite     paddr, pwdata, prdata (tick_rate @ 0x0)
//
//  an item goes from leaving the queue to the result register through one load, 34 division
//  steps and one encode when elapsed is nonzero, and through the load and the encode when it
//  is zero; the one-bit-per-cycle divider in the back finishes one item before it loads the next
//  the front takes an item in the cycle it arrives while the two-entry queue has room
//  the back keeps working on the next item while a finished result waits for pop, then holds
//  its own result until that pop; reset is synchronous, active low; tick_rate returns to 1000000
`default_nettype none

module frame_rate_seven_segment_meter #(
    parameter int COUNTER_WIDTH = frsm_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [31:0]                       i_start_count,
    input  wire logic [31:0]                       i_end_count,
    // result channel
    output logic                                   empty,
    input  wire logic                              pop,
    output logic      [7:0]                        o_tens_segments,
    output logic      [23:0]                       o_low_segments,
    output logic                                   o_zero_time,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [frsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [frsm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [frsm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int ENTRY_W = 1 + frsm_pkg::DIVIDEND_W + COUNTER_WIDTH;

    logic [frsm_pkg::TICK_RATE_W-1:0] r_tick_rate;
    logic [frsm_pkg::REG_IDX_W-1:0]   w_reg_idx;
    logic                             w_cfg_write;

    logic                             w_q_full;
    logic                             w_q_push;
    logic                             w_q_empty;
    logic                             w_q_pop;
    logic                             w_f_zero;
    logic [frsm_pkg::DIVIDEND_W-1:0]  w_f_dividend;
    logic [COUNTER_WIDTH-1:0]         w_f_divisor;
    logic [ENTRY_W-1:0]               w_q_wdata;
    logic [ENTRY_W-1:0]               w_q_rdata;

    // configuration register, word addressed
    assign w_reg_idx   = paddr[frsm_pkg::APB_ADDR_W-1:2];
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = (w_reg_idx == frsm_pkg::REG_TICK_RATE)
                       ? frsm_pkg::APB_DATA_W'(r_tick_rate) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= frsm_pkg::TICK_RATE_RESET;
        end else if (w_cfg_write && (w_reg_idx == frsm_pkg::REG_TICK_RATE)) begin
            r_tick_rate <= pwdata[frsm_pkg::TICK_RATE_W-1:0];
        end
    end

    // front: classify and scale
    frsm_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .i_push        (push),
        .o_full        (full),
        .i_start_count (i_start_count),
        .i_end_count   (i_end_count),
        .i_tick_rate   (r_tick_rate),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_zero        (w_f_zero),
        .o_dividend    (w_f_dividend),
        .o_divisor     (w_f_divisor)
    );

    assign w_q_wdata = {w_f_zero, w_f_dividend, w_f_divisor};

    // queue between front and back
    frsm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_wdata (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty)
    );

    // back: divide, convert, encode
    frsm_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .o_q_pop         (w_q_pop),
        .i_zero          (w_q_rdata[ENTRY_W-1]),
        .i_dividend      (w_q_rdata[ENTRY_W-2:COUNTER_WIDTH]),
        .i_divisor       (w_q_rdata[COUNTER_WIDTH-1:0]),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_tens_segments (o_tens_segments),
        .o_low_segments  (o_low_segments),
        .o_zero_time     (o_zero_time)
    );

endmodule

`default_nettype wire

[sv/frsm_queue.sv]
// short register queue that decouples the front from the back
`default_nettype none

module frsm_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int PTR_W = (frsm_pkg::QUEUE_DEPTH > 1) ? $clog2(frsm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(frsm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(frsm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(frsm_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] r_data [frsm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    // status and read side
    assign o_full    = (r_count == DEPTH_CNT);
    assign o_empty   = (r_count == '0);
    assign o_rdata   = r_data[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_data[r_wr_ptr] <= i_wdata;
        end
    end

`ifndef SYNTH
    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

[sv/frsm_front.sv]
// front: takes counter readings, forms elapsed time, flags zero, scales tick rate
`default_nettype none

module frsm_front #(
    parameter int COUNTER_WIDTH = frsm_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                                i_push,
    output logic                                     o_full,
    input  wire logic [31:0]                         i_start_count,
    input  wire logic [31:0]                         i_end_count,
    input  wire logic [frsm_pkg::TICK_RATE_W-1:0]    i_tick_rate,
    input  wire logic                                i_q_full,
    output logic                                     o_q_push,
    output logic                                     o_zero,
    output logic      [frsm_pkg::DIVIDEND_W-1:0]     o_dividend,
    output logic      [COUNTER_WIDTH-1:0]            o_divisor
);

    logic [63:0]              w_start_wide;
    logic [63:0]              w_end_wide;
    logic [COUNTER_WIDTH-1:0] w_start;
    logic [COUNTER_WIDTH-1:0] w_end;

    // handshake into the queue
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    // readings cut or extended to the counter width, difference wraps
    assign w_start_wide = 64'(i_start_count);
    assign w_end_wide   = 64'(i_end_count);
    assign w_start      = w_start_wide[COUNTER_WIDTH-1:0];
    assign w_end        = w_end_wide[COUNTER_WIDTH-1:0];
    assign o_divisor    = w_end - w_start;
    assign o_zero       = (o_divisor == '0);

    // numerator in hundredths
    assign o_dividend = frsm_pkg::DIVIDEND_W'(i_tick_rate)
                      * frsm_pkg::DIVIDEND_W'(frsm_pkg::RATE_SCALE);

endmodule

`default_nettype wire

[sv/frsm_back.sv]
// back: bit-serial divider feeding a truncated double-dabble, segment encode, result register
`default_nettype none

module frsm_back #(
    parameter int COUNTER_WIDTH = frsm_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_empty,
    output logic                                 o_q_pop,
    input  wire logic                            i_zero,
    input  wire logic [frsm_pkg::DIVIDEND_W-1:0] i_dividend,
    input  wire logic [COUNTER_WIDTH-1:0]        i_divisor,
    input  wire logic                            i_pop,
    output logic                                 o_empty,
    output logic      [7:0]                      o_tens_segments,
    output logic      [23:0]                     o_low_segments,
    output logic                                 o_zero_time
);

    localparam int DW    = frsm_pkg::DIVIDEND_W;
    localparam int CNT_W = $clog2(frsm_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(frsm_pkg::DIVIDEND_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [CNT_W-1:0]            r_cnt;
    logic [DW-1:0]               r_num;
    logic [COUNTER_WIDTH-1:0]    r_div;
    logic [COUNTER_WIDTH-1:0]    r_rem;
    logic [frsm_pkg::BCD_W-1:0]  r_bcd;
    logic                        r_zero;
    logic                        r_out_valid;
    logic [7:0]                  r_tens;
    logic [23:0]                 r_low;
    logic                        r_out_zero;

    logic [COUNTER_WIDTH:0]      w_trial;
    logic [COUNTER_WIDTH:0]      w_diff;
    logic                        w_ge;
    logic [COUNTER_WIDTH-1:0]    w_rem_next;
    logic [frsm_pkg::BCD_W-1:0]  w_adj;
    logic [frsm_pkg::BCD_W-1:0]  w_bcd_next;
    logic                        w_load;
    logic                        w_emit;

    // one restoring division step, quotient bit out msb first
    assign w_trial    = {r_rem, r_num[DW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_diff     = w_trial - {1'b0, r_div};
    assign w_rem_next = w_ge ? w_diff[COUNTER_WIDTH-1:0] : w_trial[COUNTER_WIDTH-1:0];

    // add-3 on each digit, then shift the quotient bit in; top carry dropped keeps mod 10000
    always_comb begin
        for (int i = 0; i < frsm_pkg::BCD_W / 4; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                        : r_bcd[4*i +: 4];
        end
    end
    assign w_bcd_next = {w_adj[frsm_pkg::BCD_W-2:0], w_ge};

    // handshakes
    assign w_load  = (r_state == ST_IDLE) && !i_q_empty;
    assign o_q_pop = w_load;
    assign w_emit  = (r_state == ST_HOLD) && (!r_out_valid || i_pop);
    assign o_empty = !r_out_valid;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = i_zero ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_num  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_zero <= i_zero;
            r_bcd  <= i_zero ? frsm_pkg::FORCED_BCD : '0;
        end else if (r_state == ST_RUN) begin
            r_num <= {r_num[DW-2:0], 1'b0};
            r_rem <= w_rem_next;
            r_bcd <= w_bcd_next;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (w_emit) begin
            r_tens     <= frsm_pkg::seg_code(r_bcd[15:12]);
            r_low      <= {frsm_pkg::seg_code(r_bcd[11:8]) & frsm_pkg::POINT_CLEAR,
                           frsm_pkg::seg_code(r_bcd[7:4]),
                           frsm_pkg::seg_code(r_bcd[3:0])};
            r_out_zero <= r_zero;
        end
    end

    assign o_tens_segments = r_tens;
    assign o_low_segments  = r_low;
    assign o_zero_time     = r_out_zero;

`ifndef SYNTH
    // a division never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_div != '0))
        else $error("division running with zero divisor");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    // every bcd digit stays decimal while working or holding
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) || (r_state == ST_HOLD)) |->
        ((r_bcd[15:12] <= 4'd9) && (r_bcd[11:8] <= 4'd9) &&
         (r_bcd[7:4] <= 4'd9) && (r_bcd[3:0] <= 4'd9)))
        else $error("bcd digit out of range");

    // last division step leads to the hold state
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && (r_cnt == LAST_STEP)) |=> (r_state == ST_HOLD))
        else $error("division did not finish after last step");
`endif

endmodule

`default_nettype wire
